@@ hdl/tcc_pkg.sv @@
`timescale 1ns / 1ps

package tcc_pkg;

    // result word width of center and radius
    localparam int OUT_W = 40;

    // quotient bits formed by each divider; a larger quotient is flagged as overflow
    localparam int QUO_W = OUT_W + 2;

    // clamp limits of the center coordinates
    localparam logic [QUO_W-1:0] CENTER_POS_LIM = QUO_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] CENTER_NEG_LIM = QUO_W'(64'd1 << (OUT_W - 1));

    // radius limit (first value out of range) and clamp value
    localparam logic [QUO_W-1:0] RADIUS_OVER = QUO_W'(64'd1 << OUT_W);
    localparam logic [OUT_W-1:0] RADIUS_MAX  = {OUT_W{1'b1}};

endpackage

@@ hdl/triangle_circumcircle.sv @@
`timescale 1ns / 1ps
// Throughput: one triangle per cycle; busy stays low and every stage advances each cycle.
// The square-root stage (one root bit per stage) and the three dividers (one quotient bit
// per stage) set the depth. The receiver cannot stall; results come once each as a strobe.
// Reset clears the valid bits of every stage; no result is in flight afterwards.

module triangle_circumcircle #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      ax,
    input  logic signed [COORD_WIDTH-1:0]      ay,
    input  logic signed [COORD_WIDTH-1:0]      bx,
    input  logic signed [COORD_WIDTH-1:0]      by_coord,
    input  logic signed [COORD_WIDTH-1:0]      cx,
    input  logic signed [COORD_WIDTH-1:0]      cy,
    output logic                               done,
    output logic signed [tcc_pkg::OUT_W-1:0]   center_x,
    output logic signed [tcc_pkg::OUT_W-1:0]   center_y,
    output logic        [tcc_pkg::OUT_W-1:0]   radius,
    output logic                               degenerate,
    output logic                               saturated
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int UW   = W + 1;
    localparam int PW   = 2 * W + 2;
    localparam int DW   = 2 * W + 3;
    localparam int SQW  = 2 * W + 2;
    localparam int NXW  = 3 * W + 4;
    localparam int TW   = 3 * W + 5;
    localparam int AW   = 3 * W + 4;
    localparam int DABW = 2 * W + 2;
    localparam int XW   = AW + F + 1;
    localparam int DENW = DABW + 1;
    localparam int HW   = (AW + 1) / 2;
    localparam int HHW  = AW - HW;
    localparam int NSW  = 2 * AW + 1;
    localparam int MW   = NSW + 2 * F;
    localparam int SW   = (MW + 1) / 2;
    localparam int RW   = SW + 2;
    localparam int QW   = tcc_pkg::QUO_W;
    localparam int OW   = tcc_pkg::OUT_W;

    assign busy = 1'b0;

    // input capture
    logic                v0_reg;
    logic signed [W-1:0] ax0_reg, ay0_reg, bx0_reg, by0_reg, cx0_reg, cy0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        ax0_reg <= ax;
        ay0_reg <= ay;
        bx0_reg <= bx;
        by0_reg <= by_coord;
        cx0_reg <= cx;
        cy0_reg <= cy;
    end

    // edge vectors
    logic                 v1_reg;
    logic signed [UW-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic signed [W-1:0]  px1_reg, py1_reg;

    always_ff @(posedge clk)
    begin
        ux1_reg <= UW'(ax0_reg) - UW'(cx0_reg);
        uy1_reg <= UW'(ay0_reg) - UW'(cy0_reg);
        vx1_reg <= UW'(bx0_reg) - UW'(cx0_reg);
        vy1_reg <= UW'(by0_reg) - UW'(cy0_reg);
        px1_reg <= cx0_reg;
        py1_reg <= cy0_reg;
    end

    // pairwise products
    logic                 v2_reg;
    logic signed [PW-1:0] uxvy2_reg, uyvx2_reg, uxux2_reg, uyuy2_reg, vxvx2_reg, vyvy2_reg;
    logic signed [UW-1:0] ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    logic signed [W-1:0]  px2_reg, py2_reg;

    always_ff @(posedge clk)
    begin
        uxvy2_reg <= PW'(ux1_reg) * PW'(vy1_reg);
        uyvx2_reg <= PW'(uy1_reg) * PW'(vx1_reg);
        uxux2_reg <= PW'(ux1_reg) * PW'(ux1_reg);
        uyuy2_reg <= PW'(uy1_reg) * PW'(uy1_reg);
        vxvx2_reg <= PW'(vx1_reg) * PW'(vx1_reg);
        vyvy2_reg <= PW'(vy1_reg) * PW'(vy1_reg);
        ux2_reg   <= ux1_reg;
        uy2_reg   <= uy1_reg;
        vx2_reg   <= vx1_reg;
        vy2_reg   <= vy1_reg;
        px2_reg   <= px1_reg;
        py2_reg   <= py1_reg;
    end

    // determinant and squared lengths
    logic                 v3_reg;
    logic signed [DW-1:0] d3_reg;
    logic        [SQW-1:0] uu3_reg, vv3_reg;
    logic signed [UW-1:0] ux3_reg, uy3_reg, vx3_reg, vy3_reg;
    logic signed [W-1:0]  px3_reg, py3_reg;

    always_ff @(posedge clk)
    begin
        d3_reg  <= DW'(uxvy2_reg) - DW'(uyvx2_reg);
        uu3_reg <= SQW'(uxux2_reg + uyuy2_reg);
        vv3_reg <= SQW'(vxvx2_reg + vyvy2_reg);
        ux3_reg <= ux2_reg;
        uy3_reg <= uy2_reg;
        vx3_reg <= vx2_reg;
        vy3_reg <= vy2_reg;
        px3_reg <= px2_reg;
        py3_reg <= py2_reg;
    end

    // numerator products and p3 * d
    logic                  v4_reg;
    logic signed [NXW-1:0] vyuu4_reg, uyvv4_reg, uxvv4_reg, vxuu4_reg;
    logic signed [TW-1:0]  pdx4_reg, pdy4_reg;
    logic signed [DW-1:0]  d4_reg;
    logic                  dg4_reg;

    always_ff @(posedge clk)
    begin
        vyuu4_reg <= NXW'(vy3_reg) * NXW'($signed({1'b0, uu3_reg}));
        uyvv4_reg <= NXW'(uy3_reg) * NXW'($signed({1'b0, vv3_reg}));
        uxvv4_reg <= NXW'(ux3_reg) * NXW'($signed({1'b0, vv3_reg}));
        vxuu4_reg <= NXW'(vx3_reg) * NXW'($signed({1'b0, uu3_reg}));
        pdx4_reg  <= TW'(px3_reg) * TW'(d3_reg);
        pdy4_reg  <= TW'(py3_reg) * TW'(d3_reg);
        d4_reg    <= d3_reg;
        dg4_reg   <= (d3_reg == '0);
    end

    // numerators
    logic                  v5_reg;
    logic signed [NXW-1:0] nx5_reg, ny5_reg;
    logic signed [TW-1:0]  pdx5_reg, pdy5_reg;
    logic signed [DW-1:0]  d5_reg;
    logic                  dg5_reg;

    always_ff @(posedge clk)
    begin
        nx5_reg  <= vyuu4_reg - uyvv4_reg;
        ny5_reg  <= uxvv4_reg - vxuu4_reg;
        pdx5_reg <= pdx4_reg;
        pdy5_reg <= pdy4_reg;
        d5_reg   <= d4_reg;
        dg5_reg  <= dg4_reg;
    end

    // center numerators t = 2*p3*d + n, magnitudes for the radius
    logic                  v6_reg;
    logic signed [TW-1:0]  tx6_reg, ty6_reg;
    logic        [AW-1:0]  anx6_reg, any6_reg;
    logic        [DABW-1:0] dab6_reg;
    logic                  dn6_reg;
    logic                  dg6_reg;

    always_ff @(posedge clk)
    begin
        tx6_reg  <= (pdx5_reg <<< 1) + TW'(nx5_reg);
        ty6_reg  <= (pdy5_reg <<< 1) + TW'(ny5_reg);
        anx6_reg <= nx5_reg[NXW-1] ? AW'(-nx5_reg) : AW'(nx5_reg);
        any6_reg <= ny5_reg[NXW-1] ? AW'(-ny5_reg) : AW'(ny5_reg);
        dab6_reg <= d5_reg[DW-1] ? DABW'(-d5_reg) : DABW'(d5_reg);
        dn6_reg  <= d5_reg[DW-1];
        dg6_reg  <= dg5_reg;
    end

    // rounding-biased dividends and partial squares
    logic                  v7_reg;
    logic        [XW-1:0]  xx7_reg, xy7_reg;
    logic                  ngx7_reg, ngy7_reg;
    logic        [2*HHW-1:0]  hhx7_reg, hhy7_reg;
    logic        [HHW+HW-1:0] hlx7_reg, hly7_reg;
    logic        [2*HW-1:0]   llx7_reg, lly7_reg;
    logic        [DABW-1:0] dab7_reg;
    logic                  dg7_reg;
    logic        [AW-1:0]  atx6_next, aty6_next;

    always_comb
    begin
        atx6_next = tx6_reg[TW-1] ? AW'(-tx6_reg) : AW'(tx6_reg);
        aty6_next = ty6_reg[TW-1] ? AW'(-ty6_reg) : AW'(ty6_reg);
    end

    always_ff @(posedge clk)
    begin
        xx7_reg  <= (XW'(atx6_next) << F) + XW'(dab6_reg);
        xy7_reg  <= (XW'(aty6_next) << F) + XW'(dab6_reg);
        ngx7_reg <= tx6_reg[TW-1] ^ dn6_reg;
        ngy7_reg <= ty6_reg[TW-1] ^ dn6_reg;
        hhx7_reg <= (2*HHW)'(anx6_reg[AW-1:HW]) * (2*HHW)'(anx6_reg[AW-1:HW]);
        hhy7_reg <= (2*HHW)'(any6_reg[AW-1:HW]) * (2*HHW)'(any6_reg[AW-1:HW]);
        hlx7_reg <= (HHW+HW)'(anx6_reg[AW-1:HW]) * (HHW+HW)'(anx6_reg[HW-1:0]);
        hly7_reg <= (HHW+HW)'(any6_reg[AW-1:HW]) * (HHW+HW)'(any6_reg[HW-1:0]);
        llx7_reg <= (2*HW)'(anx6_reg[HW-1:0]) * (2*HW)'(anx6_reg[HW-1:0]);
        lly7_reg <= (2*HW)'(any6_reg[HW-1:0]) * (2*HW)'(any6_reg[HW-1:0]);
        dab7_reg <= dab6_reg;
        dg7_reg  <= dg6_reg;
    end

    // square-root pipeline; index 0 receives |n|^2 scaled by 2^(2F)
    logic              sq_v_reg   [0:SW];
    logic [2*SW-1:0]   sq_m_reg   [0:SW];
    logic [SW-1:0]     sq_rt_reg  [0:SW];
    logic [RW-1:0]     sq_rm_reg  [0:SW];
    logic [XW-1:0]     sq_xx_reg  [0:SW];
    logic [XW-1:0]     sq_xy_reg  [0:SW];
    logic              sq_ngx_reg [0:SW];
    logic              sq_ngy_reg [0:SW];
    logic [DABW-1:0]   sq_dab_reg [0:SW];
    logic              sq_dg_reg  [0:SW];
    logic [NSW-1:0]    nsq7_next;

    always_comb
    begin
        nsq7_next = (NSW'(hhx7_reg) << (2 * HW)) + (NSW'(hlx7_reg) << (HW + 1))
                  + NSW'(llx7_reg)
                  + (NSW'(hhy7_reg) << (2 * HW)) + (NSW'(hly7_reg) << (HW + 1))
                  + NSW'(lly7_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            sq_v_reg[0] <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_m_reg[0]   <= (2*SW)'(nsq7_next) << (2 * F);
        sq_rt_reg[0]  <= '0;
        sq_rm_reg[0]  <= '0;
        sq_xx_reg[0]  <= xx7_reg;
        sq_xy_reg[0]  <= xy7_reg;
        sq_ngx_reg[0] <= ngx7_reg;
        sq_ngy_reg[0] <= ngy7_reg;
        sq_dab_reg[0] <= dab7_reg;
        sq_dg_reg[0]  <= dg7_reg;
    end

    for (genvar j = 0; j < SW; j++)
    begin : g_root
        logic [RW-1:0] rm_shift;
        logic [RW-1:0] trial;
        logic          ge;

        always_comb
        begin
            rm_shift = {sq_rm_reg[j][RW-3:0], sq_m_reg[j][2*SW-1 -: 2]};
            trial    = {sq_rt_reg[j], 2'b01};
            ge       = (rm_shift >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j+1] <= 1'b0;
            end
            else
            begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_m_reg[j+1]   <= sq_m_reg[j] << 2;
            sq_rt_reg[j+1]  <= {sq_rt_reg[j][SW-2:0], ge};
            sq_rm_reg[j+1]  <= ge ? (rm_shift - trial) : rm_shift;
            sq_xx_reg[j+1]  <= sq_xx_reg[j];
            sq_xy_reg[j+1]  <= sq_xy_reg[j];
            sq_ngx_reg[j+1] <= sq_ngx_reg[j];
            sq_ngy_reg[j+1] <= sq_ngy_reg[j];
            sq_dab_reg[j+1] <= sq_dab_reg[j];
            sq_dg_reg[j+1]  <= sq_dg_reg[j];
        end
    end

    // dividers: two centers by 2|d|, root by |d|
    logic          dv_valid;
    logic          dx_neg, dy_neg, dr_dg;
    logic [QW-1:0] qx, qy, qr;
    logic          ox, oy, orr;

    tcc_div_pipe #(
        .NUM_W (XW),
        .DEN_W (DENW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sq_v_reg[SW]),
        .tag_in    (sq_ngx_reg[SW]),
        .num       (sq_xx_reg[SW]),
        .den       ({sq_dab_reg[SW], 1'b0}),
        .valid_out (),
        .tag_out   (dx_neg),
        .quo       (qx),
        .ovf       (ox)
    );

    tcc_div_pipe #(
        .NUM_W (XW),
        .DEN_W (DENW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sq_v_reg[SW]),
        .tag_in    (sq_ngy_reg[SW]),
        .num       (sq_xy_reg[SW]),
        .den       ({sq_dab_reg[SW], 1'b0}),
        .valid_out (),
        .tag_out   (dy_neg),
        .quo       (qy),
        .ovf       (oy)
    );

    tcc_div_pipe #(
        .NUM_W (SW),
        .DEN_W (DABW)
    ) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sq_v_reg[SW]),
        .tag_in    (sq_dg_reg[SW]),
        .num       (sq_rt_reg[SW]),
        .den       (sq_dab_reg[SW]),
        .valid_out (dv_valid),
        .tag_out   (dr_dg),
        .quo       (qr),
        .ovf       (orr)
    );

    // clamp, sign and round radius
    logic          satx_next, saty_next, satr_next;
    logic [QW-1:0] limx_next, limy_next;
    logic [QW-1:0] valx_next, valy_next;
    logic [QW:0]   rr_next;
    logic [OW-1:0] cx_next, cy_next, r_next;

    always_comb
    begin
        limx_next = dx_neg ? tcc_pkg::CENTER_NEG_LIM : tcc_pkg::CENTER_POS_LIM;
        limy_next = dy_neg ? tcc_pkg::CENTER_NEG_LIM : tcc_pkg::CENTER_POS_LIM;
        satx_next = ox | (qx > limx_next);
        saty_next = oy | (qy > limy_next);
        valx_next = satx_next ? limx_next : qx;
        valy_next = saty_next ? limy_next : qy;
        cx_next   = dx_neg ? OW'(-valx_next) : OW'(valx_next);
        cy_next   = dy_neg ? OW'(-valy_next) : OW'(valy_next);
        rr_next   = ((QW+1)'(qr) + (QW+1)'(1)) >> 1;
        satr_next = orr | (rr_next >= (QW+1)'(tcc_pkg::RADIUS_OVER));
        r_next    = satr_next ? tcc_pkg::RADIUS_MAX : OW'(rr_next);
    end

    logic          done_reg;
    logic [OW-1:0] cx_reg, cy_reg, r_reg;
    logic          dg_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    // collinear vertices drop the center, the radius and the saturated flag to zero
    always_ff @(posedge clk)
    begin
        cx_reg  <= dr_dg ? '0 : cx_next;
        cy_reg  <= dr_dg ? '0 : cy_next;
        r_reg   <= dr_dg ? '0 : r_next;
        dg_reg  <= dr_dg;
        sat_reg <= ~dr_dg & (satx_next | saty_next | satr_next);
    end

    assign done       = done_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign radius     = r_reg;
    assign degenerate = dg_reg;
    assign saturated  = sat_reg;

endmodule

@@ hdl/tcc_div_pipe.sv @@
`timescale 1ns / 1ps

module tcc_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic                         tag_in,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output logic                         valid_out,
    output logic                         tag_out,
    output logic [tcc_pkg::QUO_W-1:0]    quo,
    output logic                         ovf
);

    localparam int QW = tcc_pkg::QUO_W;
    localparam int EW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic             valid_reg [0:QW];
    logic             tag_reg   [0:QW];
    logic             ovf_reg   [0:QW];
    logic [DEN_W-1:0] den_reg   [0:QW];
    logic [DEN_W-1:0] rem_reg   [0:QW];
    logic [QW-1:0]    low_reg   [0:QW];
    logic [QW-1:0]    quo_reg   [0:QW];

    logic [EW-1:0]    num_ext;
    logic [EW-1:0]    den_shift;

    assign num_ext   = EW'(num);
    assign den_shift = EW'(den) << QW;

    // entry stage: overflow test and split of the dividend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        ovf_reg[0] <= (num_ext >= den_shift);
        den_reg[0] <= den;
        rem_reg[0] <= num_ext[QW +: DEN_W];
        low_reg[0] <= num_ext[QW-1:0];
        quo_reg[0] <= '0;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][QW-1]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1] <= tag_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            den_reg[k+1] <= den_reg[k];
            rem_reg[k+1] <= rem_next;
            low_reg[k+1] <= low_reg[k] << 1;
            quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
        end
    end

    assign valid_out = valid_reg[QW];
    assign tag_out   = tag_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];

endmodule
